### hw/rtl/aim_pkg.sv
// ----------------------------------------------------------------------------
// aim_pkg
// Shared types, constants and register indexes of the adaptive interrupt
// moderation unit.
// ----------------------------------------------------------------------------
package aim_pkg;

   localparam int NUM_QUEUES_DEF = 64;
   localparam int TICKS_PER_SECOND_DEF = 1000;
   localparam int LOWEST_LATENCY_TIMER_DEF = 1;
   localparam int SMALL_PACKET_BYTES_DEF = 128;

   localparam int QIDX_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADAPT_ENABLE   = 3'd0,
      CSR_RATE_THRESHOLD = 3'd1,
      CSR_RATE_LOW       = 3'd2,
      CSR_RATE_HIGH      = 3'd3,
      CSR_USECS_LOW      = 3'd4,
      CSR_USECS_HIGH     = 3'd5,
      CSR_PENDING_LOW    = 3'd6,
      CSR_PENDING_HIGH   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [5:0]  queue_index;
      logic [63:0] rx_packet_count;
      logic [63:0] rx_byte_count;
      logic [31:0] period_ticks;
      logic        queue_active;
   } req_word_type;

   typedef struct packed {
      logic       write_valid;
      logic [5:0] out_queue;
      logic [7:0] moderation_timer;
      logic [7:0] pend_limit;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_DIV_AVG,
      ST_DIV_WHOLE,
      ST_DIV_FRAC,
      ST_RATE,
      ST_CHOOSE,
      ST_DIV_INTERP,
      ST_WRITE,
      ST_RESP
   } state_type;

   // divider start / status between sequencer and divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

endpackage

### hw/rtl/adaptive_irq_moderation_unit.sv
// One word at a time: the unit takes no new word until the response for the last
// one is taken; each word needs up to four passes of the shared divider plus
// the sequencer steps.
// Reset: synchronous, clears the state and configuration registers, then a
// clearing pass zeroes every per-queue store entry (64 by default) before the first word.
// ----------------------------------------------------------------------------
// adaptive_irq_moderation_unit
// Per-queue adaptive receive interrupt moderation driven by counter samples.
// ----------------------------------------------------------------------------
module adaptive_irq_moderation_unit #(
   parameter int NUM_QUEUES           = aim_pkg::NUM_QUEUES_DEF,
   parameter int TICKS_PER_SECOND     = aim_pkg::TICKS_PER_SECOND_DEF,
   parameter int LOWEST_LATENCY_TIMER = aim_pkg::LOWEST_LATENCY_TIMER_DEF,
   parameter int SMALL_PACKET_BYTES   = aim_pkg::SMALL_PACKET_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  aim_pkg::req_word_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output aim_pkg::rsp_word_type          rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [aim_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aim_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import aim_pkg::*;

   localparam int AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int DEPTH = 1 << AW;
   localparam logic [63:0] TPS = 64'(TICKS_PER_SECOND);
   localparam logic [63:0] SMALL = 64'(SMALL_PACKET_BYTES);
   localparam logic [7:0] LLT = 8'(LOWEST_LATENCY_TIMER);

   // configuration registers
   logic        en_ff;
   logic [31:0] thr_ff, rlo_ff, rhi_ff;
   logic [7:0]  ulo_ff, uhi_ff, plo_ff, phi_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0; thr_ff <= '0; rlo_ff <= '0; rhi_ff <= '0;
         ulo_ff <= '0; uhi_ff <= '0; plo_ff <= '0; phi_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ADAPT_ENABLE:   en_ff  <= csr_wdata[0];
            CSR_RATE_THRESHOLD: thr_ff <= csr_wdata;
            CSR_RATE_LOW:       rlo_ff <= csr_wdata;
            CSR_RATE_HIGH:      rhi_ff <= csr_wdata;
            CSR_USECS_LOW:      ulo_ff <= csr_wdata[7:0];
            CSR_USECS_HIGH:     uhi_ff <= csr_wdata[7:0];
            CSR_PENDING_LOW:    plo_ff <= csr_wdata[7:0];
            CSR_PENDING_HIGH:   phi_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer registers
   state_type    st_ff, st_in;
   logic [AW:0]  clr_ff, clr_in;
   req_word_type req_ff, req_in;
   logic [63:0]  diff_ff, diff_in;
   logic [63:0]  avg_ff, avg_in;
   logic [63:0]  whole_ff, whole_in;
   logic [63:0]  acc_ff, acc_in;
   logic [7:0]   tim_ff, tim_in;
   logic [7:0]   pend_ff, pend_in;
   logic         interp_up_ff, interp_up_in;
   rsp_word_type rsp_ff, rsp_in;

   // per-queue stores
   logic [AW-1:0] rd_addr, wr_addr;
   logic          cnt_we, mod_we;
   logic [63:0]   wr_pk, wr_by, rd_pk, rd_by;
   logic [15:0]   wr_mod, rd_mod;

   aim_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_pk (
      .clock(clock), .wr_en(cnt_we), .wr_addr(wr_addr), .wr_data(wr_pk),
      .rd_addr(rd_addr), .rd_data(rd_pk));
   aim_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_by (
      .clock(clock), .wr_en(cnt_we), .wr_addr(wr_addr), .wr_data(wr_by),
      .rd_addr(rd_addr), .rd_data(rd_by));
   aim_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_mod (
      .clock(clock), .wr_en(mod_we), .wr_addr(wr_addr), .wr_data(wr_mod),
      .rd_addr(rd_addr), .rd_data(rd_mod));

   div_req_type div_req;
   div_rsp_type div_rsp;

   aim_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   logic        q_ok;
   logic [63:0] rest_x;
   logic [63:0] rate_w;
   logic [64:0] sum_w;
   logic [63:0] num_w, den_w;
   logic [7:0]  udiff_w;
   logic [39:0] prod_w;
   logic [8:0]  tsum_w;

   assign q_ok   = {{(64 - QIDX_W){1'b0}}, req_ff.queue_index} < 64'(NUM_QUEUES);
   assign rd_addr = AW'(req_ff.queue_index);
   // remainder < 2^32
   assign rest_x = {32'd0, div_rsp.remainder[31:0]} * TPS;
   assign num_w  = acc_ff - {32'd0, rlo_ff};
   assign den_w  = {32'd0, rhi_ff} - {32'd0, rlo_ff};
   assign udiff_w = (uhi_ff >= ulo_ff) ? (uhi_ff - ulo_ff) : (ulo_ff - uhi_ff);
   // num < 2^32 inside the range, so a 32 x 8 product
   assign prod_w = num_w[31:0] * udiff_w;

   // next state and datapath control
   always_comb begin
      st_in = st_ff; clr_in = clr_ff; req_in = req_ff;
      diff_in = diff_ff; avg_in = avg_ff;
      whole_in = whole_ff; acc_in = acc_ff; tim_in = tim_ff; pend_in = pend_ff;
      interp_up_in = interp_up_ff; rsp_in = rsp_ff;
      cnt_we = 1'b0; mod_we = 1'b0;
      wr_addr = AW'(req_ff.queue_index);
      wr_pk = req_ff.rx_packet_count; wr_by = req_ff.rx_byte_count;
      wr_mod = {tim_ff, pend_ff};
      div_req = '{start: 1'b0, dividend: '0, divisor: 64'd1};
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rate_w = '0; sum_w = '0; tsum_w = '0;
      case (st_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1; mod_we = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_pk = '0; wr_by = '0; wr_mod = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW + 1)'(DEPTH - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_valid ? req_data : req_ff;
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            // store read is under way; drop ignored samples
            rsp_in = '{write_valid: 1'b0, out_queue: req_ff.queue_index,
                       moderation_timer: 8'd0, pend_limit: 8'd0};
            if (!en_ff || req_ff.period_ticks == 32'd0 || !q_ok) st_in = ST_RESP;
            else st_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = req_ff.rx_packet_count - rd_pk;
            st_in = ST_DIV_AVG;
            if (req_ff.rx_packet_count != rd_pk) begin
               div_req = '{start: 1'b1, dividend: req_ff.rx_byte_count - rd_by,
                           divisor: req_ff.rx_packet_count - rd_pk};
            end
         end
         ST_DIV_AVG: begin
            if (diff_ff == 64'd0) begin
               avg_in = '0;
               div_req = '{start: 1'b1, dividend: diff_ff,
                           divisor: {32'd0, req_ff.period_ticks}};
               st_in = ST_DIV_WHOLE;
            end else if (div_rsp.done) begin
               avg_in = div_rsp.quotient;
               div_req = '{start: 1'b1, dividend: diff_ff,
                           divisor: {32'd0, req_ff.period_ticks}};
               st_in = ST_DIV_WHOLE;
            end
         end
         ST_DIV_WHOLE: begin
            if (div_rsp.done) begin
               whole_in = div_rsp.quotient;
               // remainder < 2^32, times ticks fits in 64 bits
               div_req = '{start: 1'b1, dividend: rest_x,
                           divisor: {32'd0, req_ff.period_ticks}};
               st_in = ST_DIV_FRAC;
            end
         end
         ST_DIV_FRAC: begin
            if (div_rsp.done) begin
               acc_in = div_rsp.quotient;
               st_in = ST_RATE;
            end
         end
         ST_RATE: begin
            // saturating whole * ticks + frac
            rate_w = whole_ff * TPS;
            sum_w  = {1'b0, rate_w} + {1'b0, acc_ff};
            if (whole_ff != 64'd0 && (whole_ff > (64'hFFFF_FFFF_FFFF_FFFF / TPS)
                || sum_w[64])) acc_in = '1;
            else acc_in = sum_w[63:0];
            st_in = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            pend_in = plo_ff;
            interp_up_in = (uhi_ff >= ulo_ff);
            st_in = ST_WRITE;
            if (!(acc_ff > {32'd0, thr_ff} && avg_ff > SMALL)) begin
               tim_in = LLT;
            end else if (acc_ff < {32'd0, rlo_ff}) begin
               tim_in = ulo_ff;
            end else if (acc_ff > {32'd0, rhi_ff}) begin
               tim_in = uhi_ff; pend_in = phi_ff;
            end else if (rhi_ff == rlo_ff) begin
               tim_in = ulo_ff;
            end else begin
               // start the interpolation divide
               div_req = '{start: 1'b1, dividend: {24'd0, prod_w}, divisor: den_w};
               st_in = ST_DIV_INTERP;
            end
         end
         ST_DIV_INTERP: begin
            // quotient never exceeds the timer span
            if (div_rsp.done) begin
               tsum_w = interp_up_ff ? ({1'b0, ulo_ff} + {1'b0, div_rsp.quotient[7:0]})
                                     : ({1'b0, ulo_ff} - {1'b0, div_rsp.quotient[7:0]});
               tim_in = tsum_w[7:0];
               st_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cnt_we = 1'b1;
            if (({tim_ff, pend_ff} != rd_mod) && req_ff.queue_active) begin
               mod_we = 1'b1;
               rsp_in = '{write_valid: 1'b1, out_queue: req_ff.queue_index,
                          moderation_timer: tim_ff, pend_limit: pend_ff};
            end
            st_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
      end
      req_ff <= req_in; diff_ff <= diff_in;
      avg_ff <= avg_in; whole_ff <= whole_in; acc_ff <= acc_in;
      tim_ff <= tim_in; pend_ff <= pend_in; interp_up_ff <= interp_up_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // checks
   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req_ready) else $error("ready outside idle");
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.write_valid) |->
      (rsp_data.moderation_timer == 8'd0 && rsp_data.pend_limit == 8'd0))
      else $error("fields not zero without write");
   a_resp_after_write: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WRITE) |=> rsp_valid) else $error("no response after write");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CLEAR) |-> (!req_ready && !rsp_valid)) else $error("busy clear");

endmodule

### hw/rtl/aim_ram.sv
// ----------------------------------------------------------------------------
// aim_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module aim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/aim_divider.sv
// ----------------------------------------------------------------------------
// aim_divider
// Shared 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aim_divider (
   input  logic                clock,
   input  logic                reset,
   input  aim_pkg::div_req_type div_req,
   output aim_pkg::div_rsp_type div_rsp
);
   import aim_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // load the operands on start; else shift one dividend bit into the remainder and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
